>>> rtl/false_color_heat_map_top_defines.svh
// Assertion macros used by the verification checker of the heat map block.
`ifndef FALSE_COLOR_HEAT_MAP_TOP_DEFINES_SVH
`define FALSE_COLOR_HEAT_MAP_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FCHM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define FCHM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/fchm_pkg.sv
package fchm_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W    = 32;
    localparam int CHANNEL_W   = 8;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 1;

    // Default number of fractional bits of the normalized level.
    localparam int FRACTION_BITS_DEFAULT = 10;

    // Full channel intensity.
    localparam logic [CHANNEL_W-1:0] CHANNEL_MAX = 8'd255;

    // Reset values of the range registers.
    localparam logic [SAMPLE_W-1:0] RANGE_MINIMUM_RESET = 32'd0;
    localparam logic [SAMPLE_W-1:0] RANGE_MAXIMUM_RESET = 32'd100;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RANGE_MINIMUM = 1'b0,
        REG_RANGE_MAXIMUM = 1'b1
    } cfg_reg_t;

    // Range status of a sample.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_INSIDE = 2'd0,
        STATUS_BELOW  = 2'd1,
        STATUS_ABOVE  = 2'd2
    } clamp_status_t;

    // Divider state that does not depend on the fraction width.
    typedef struct packed {
        logic [SAMPLE_W-1:0] den;
        logic [SAMPLE_W-1:0] rem;
        clamp_status_t       status;
    } div_fixed_t;

endpackage

>>> rtl/fchm_prep.sv
module fchm_prep #(
    parameter int FRACTION_BITS = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [fchm_pkg::SAMPLE_W-1:0] sample_value,
    input  logic signed [fchm_pkg::SAMPLE_W-1:0] range_minimum,
    input  logic signed [fchm_pkg::SAMPLE_W-1:0] range_maximum,
    output logic                                 down_valid,
    input  logic                                 down_ready,
    output fchm_pkg::div_fixed_t                 down_fix,
    output logic [FRACTION_BITS:0]               down_quo
);
    import fchm_pkg::*;

    localparam logic [FRACTION_BITS:0] LEVEL_FULL = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [FRACTION_BITS:0] LEVEL_ZERO = '0;

    logic                   valid_reg;
    div_fixed_t             fix_reg;
    div_fixed_t             fix_next;
    logic [FRACTION_BITS:0] quo_reg;
    logic [FRACTION_BITS:0] quo_next;
    logic [SAMPLE_W:0]      num_wide;
    logic [SAMPLE_W:0]      den_wide;
    logic                   empty_range;
    logic                   below_min;
    logic                   equal_min;
    logic                   above_max;
    logic                   equal_max;
    logic                   load;

    // Differences taken one bit wider; only the low bits are kept when in range.
    assign num_wide = {sample_value[SAMPLE_W-1], sample_value}
                    - {range_minimum[SAMPLE_W-1], range_minimum};
    assign den_wide = {range_maximum[SAMPLE_W-1], range_maximum}
                    - {range_minimum[SAMPLE_W-1], range_minimum};

    // Range comparisons run in parallel with the subtractions.
    assign empty_range = !(range_maximum > range_minimum);
    assign below_min   = sample_value < range_minimum;
    assign equal_min   = sample_value == range_minimum;
    assign above_max   = sample_value > range_maximum;
    assign equal_max   = sample_value == range_maximum;

    // Classify the sample and seed the divider. Forced levels get a zero remainder,
    // and clamped ones an all-ones divisor, so the later steps add no quotient bits.
    always_comb
    begin
        fix_next.den    = '1;
        fix_next.rem    = '0;
        fix_next.status = STATUS_INSIDE;
        quo_next        = LEVEL_ZERO;
        priority if (empty_range)
        begin
            if (below_min)
            begin
                fix_next.status = STATUS_BELOW;
            end
            else if (!equal_min)
            begin
                fix_next.status = STATUS_ABOVE;
                quo_next        = LEVEL_FULL;
            end
        end
        else if (below_min)
        begin
            fix_next.status = STATUS_BELOW;
        end
        else if (above_max)
        begin
            fix_next.status = STATUS_ABOVE;
            quo_next        = LEVEL_FULL;
        end
        else
        begin
            fix_next.den = den_wide[SAMPLE_W-1:0];
            if (equal_max)
            begin
                quo_next = LEVEL_FULL;
            end
            else
            begin
                fix_next.rem = num_wide[SAMPLE_W-1:0];
            end
        end
    end

    // Stage handshake.
    assign in_ready = !valid_reg || down_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fix_reg <= fix_next;
            quo_reg <= quo_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_fix   = fix_reg;
    assign down_quo   = quo_reg;

endmodule

>>> rtl/fchm_div_step.sv
module fchm_div_step #(
    parameter int FRACTION_BITS = 10,
    parameter int QUO_BIT       = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   up_valid,
    output logic                   up_ready,
    input  fchm_pkg::div_fixed_t   up_fix,
    input  logic [FRACTION_BITS:0] up_quo,
    output logic                   down_valid,
    input  logic                   down_ready,
    output fchm_pkg::div_fixed_t   down_fix,
    output logic [FRACTION_BITS:0] down_quo
);
    import fchm_pkg::*;

    logic                   valid_reg;
    div_fixed_t             fix_reg;
    div_fixed_t             fix_next;
    logic [FRACTION_BITS:0] quo_reg;
    logic [FRACTION_BITS:0] quo_next;
    logic [SAMPLE_W:0]      rem_shift;
    logic [SAMPLE_W:0]      rem_diff;
    logic                   fits;
    logic                   load;

    // One restoring step: shift the remainder, subtract the divisor if it fits.
    assign rem_shift = {up_fix.rem, 1'b0};
    assign rem_diff  = rem_shift - {1'b0, up_fix.den};
    assign fits      = rem_shift >= {1'b0, up_fix.den};

    always_comb
    begin
        fix_next          = up_fix;
        fix_next.rem      = fits ? rem_diff[SAMPLE_W-1:0] : rem_shift[SAMPLE_W-1:0];
        quo_next          = up_quo;
        quo_next[QUO_BIT] = fits;
    end

    // Stage handshake.
    assign up_ready = !valid_reg || down_ready;
    assign load     = up_valid && up_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fix_reg <= fix_next;
            quo_reg <= quo_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_fix   = fix_reg;
    assign down_quo   = quo_reg;

endmodule

>>> rtl/fchm_ramp.sv
module fchm_ramp #(
    parameter int FRACTION_BITS = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  up_valid,
    output logic                                  up_ready,
    input  logic [FRACTION_BITS:0]                up_level,
    input  fchm_pkg::clamp_status_t               up_status,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [fchm_pkg::CHANNEL_W-1:0]        red,
    output logic [fchm_pkg::CHANNEL_W-1:0]        green,
    output logic [fchm_pkg::CHANNEL_W-1:0]        blue,
    output logic [fchm_pkg::STATUS_W-1:0]         clamp_status
);
    import fchm_pkg::*;

    localparam int FRAC_W = FRACTION_BITS - 2;
    localparam int PROD_W = FRACTION_BITS + 7;
    localparam logic [FRAC_W:0] QUARTER = {1'b1, {FRAC_W{1'b0}}};

    // Quarter of the scale that the level falls in.
    typedef enum logic [1:0] {
        SEG_BLUE_CYAN    = 2'd0,
        SEG_CYAN_GREEN   = 2'd1,
        SEG_GREEN_YELLOW = 2'd2,
        SEG_YELLOW_RED   = 2'd3
    } ramp_seg_t;

    // Scale a ramp position within a quarter to 0..255, truncating.
    function automatic logic [CHANNEL_W-1:0] scale_quarter(input logic [FRAC_W:0] pos);
        logic [PROD_W-1:0] prod;
        prod = {pos, 8'b0} - PROD_W'(pos);
        return prod[FRAC_W+CHANNEL_W-1:FRAC_W];
    endfunction

    logic                 valid_reg;
    logic [CHANNEL_W-1:0] red_reg;
    logic [CHANNEL_W-1:0] green_reg;
    logic [CHANNEL_W-1:0] blue_reg;
    clamp_status_t        status_reg;
    logic [CHANNEL_W-1:0] red_next;
    logic [CHANNEL_W-1:0] green_next;
    logic [CHANNEL_W-1:0] blue_next;
    ramp_seg_t            seg;
    logic [FRAC_W-1:0]    offset;
    logic [CHANNEL_W-1:0] rise;
    logic [CHANNEL_W-1:0] fall;
    logic                 load;

    // Rising and falling ramp values within the current quarter.
    assign seg    = ramp_seg_t'(up_level[FRACTION_BITS-1:FRACTION_BITS-2]);
    assign offset = up_level[FRAC_W-1:0];
    assign rise   = scale_quarter({1'b0, offset});
    assign fall   = scale_quarter(QUARTER - {1'b0, offset});

    // Channel selection by quarter; full level is pure red.
    always_comb
    begin
        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
        if (up_level[FRACTION_BITS])
        begin
            red_next = CHANNEL_MAX;
        end
        else
        begin
            unique case (seg)
                SEG_BLUE_CYAN:
                begin
                    green_next = rise;
                    blue_next  = CHANNEL_MAX;
                end
                SEG_CYAN_GREEN:
                begin
                    green_next = CHANNEL_MAX;
                    blue_next  = fall;
                end
                SEG_GREEN_YELLOW:
                begin
                    red_next   = rise;
                    green_next = CHANNEL_MAX;
                end
                SEG_YELLOW_RED:
                begin
                    red_next   = CHANNEL_MAX;
                    green_next = fall;
                end
            endcase
        end
    end

    // Output register; holds the result while the consumer stalls.
    assign up_ready = !valid_reg || out_ready;
    assign load     = up_valid && up_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
            status_reg <= up_status;
        end
    end

    assign out_valid    = valid_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign clamp_status = status_reg;

endmodule

>>> rtl/false_color_heat_map_top.sv
// Jet false-color map: each signed sample is normalized against range_minimum
// and range_maximum into a level of FRACTION_BITS fractional bits, clamped to
// 0..1, and turned into an 8-bit red, green and blue color on a blue, cyan,
// green, yellow, red ramp, with clamp_status telling whether the sample lay
// inside, below or above the range. The block takes one sample every clock
// unless the output stalls, and its color passes through these stages in order:
// one stage classifies the sample and forms the differences, a divider of
// FRACTION_BITS stages resolves one quotient bit per stage with a 33-bit
// compare and subtract, and one stage evaluates the ramp into the output
// register. Back-pressure on the output stalls the pipeline without losing
// samples, and empty stages keep filling while the output waits. The range
// registers are written through the cfg port and must only change while no
// sample is in flight.
module false_color_heat_map_top #(
    parameter int FRACTION_BITS = fchm_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_enable,
    input  logic [fchm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fchm_pkg::SAMPLE_W-1:0]        cfg_write_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [fchm_pkg::SAMPLE_W-1:0] sample_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [fchm_pkg::CHANNEL_W-1:0]       red,
    output logic [fchm_pkg::CHANNEL_W-1:0]       green,
    output logic [fchm_pkg::CHANNEL_W-1:0]       blue,
    output logic [fchm_pkg::STATUS_W-1:0]        clamp_status
);
    import fchm_pkg::*;

    logic [SAMPLE_W-1:0]    range_minimum_reg;
    logic [SAMPLE_W-1:0]    range_maximum_reg;

    logic                   stage_valid [0:FRACTION_BITS];
    logic                   stage_ready [0:FRACTION_BITS];
    div_fixed_t             stage_fix   [0:FRACTION_BITS];
    logic [FRACTION_BITS:0] stage_quo   [0:FRACTION_BITS];

    // Range registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_minimum_reg <= RANGE_MINIMUM_RESET;
            range_maximum_reg <= RANGE_MAXIMUM_RESET;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_RANGE_MINIMUM: range_minimum_reg <= cfg_write_data;
                REG_RANGE_MAXIMUM: range_maximum_reg <= cfg_write_data;
            endcase
        end
    end

    // Classification and divider seeding.
    fchm_prep #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_prep (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_value  (sample_value),
        .range_minimum ($signed(range_minimum_reg)),
        .range_maximum ($signed(range_maximum_reg)),
        .down_valid    (stage_valid[0]),
        .down_ready    (stage_ready[0]),
        .down_fix      (stage_fix[0]),
        .down_quo      (stage_quo[0])
    );

    // Pipelined restoring divider, most significant fraction bit first.
    for (genvar k = 0; k < FRACTION_BITS; k++)
    begin : g_div
        fchm_div_step #(
            .FRACTION_BITS (FRACTION_BITS),
            .QUO_BIT       (FRACTION_BITS - 1 - k)
        ) u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (stage_valid[k]),
            .up_ready   (stage_ready[k]),
            .up_fix     (stage_fix[k]),
            .up_quo     (stage_quo[k]),
            .down_valid (stage_valid[k+1]),
            .down_ready (stage_ready[k+1]),
            .down_fix   (stage_fix[k+1]),
            .down_quo   (stage_quo[k+1])
        );
    end

    // Color ramp and output register.
    fchm_ramp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ramp (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (stage_valid[FRACTION_BITS]),
        .up_ready     (stage_ready[FRACTION_BITS]),
        .up_level     (stage_quo[FRACTION_BITS]),
        .up_status    (stage_fix[FRACTION_BITS].status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .clamp_status (clamp_status)
    );

endmodule

>>> rtl/fchm_checker.sv
`include "false_color_heat_map_top_defines.svh"

module fchm_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic [fchm_pkg::CHANNEL_W-1:0]       red,
    input logic [fchm_pkg::CHANNEL_W-1:0]       green,
    input logic [fchm_pkg::CHANNEL_W-1:0]       blue,
    input logic [fchm_pkg::STATUS_W-1:0]        clamp_status
);
    import fchm_pkg::*;

    logic                                 out_stall;
    logic                                 clamped_below;
    logic                                 clamped_above;
    logic [3*CHANNEL_W+STATUS_W:0]        held_result;
    logic                                 any_full;
    logic                                 no_purple;
    logic                                 color_blue;
    logic                                 color_red;

    assign out_stall     = out_valid && !out_ready;
    assign clamped_below = out_valid && (clamp_status == STATUS_BELOW);
    assign clamped_above = out_valid && (clamp_status == STATUS_ABOVE);
    assign held_result   = {out_valid, red, green, blue, clamp_status};
    assign any_full      = (red == CHANNEL_MAX) || (green == CHANNEL_MAX)
                         || (blue == CHANNEL_MAX);
    assign no_purple     = (red == '0) || (blue == '0);
    assign color_blue    = (red == '0) && (green == '0) && (blue == CHANNEL_MAX);
    assign color_red     = (red == CHANNEL_MAX) && (green == '0) && (blue == '0);

    // A stalled result transfer keeps its color.
    `FCHM_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_stall, $stable(held_result), "stall changed")

    // Every ramp color has at least one channel at full intensity.
    `FCHM_ASSERT_NOW(a_one_full, clk, rst_n, out_valid, any_full, "no channel at full intensity")

    // Red and blue never mix on the ramp.
    `FCHM_ASSERT_NOW(a_no_purple, clk, rst_n, out_valid, no_purple, "red and blue both lit")

    // A sample below the range shows pure blue.
    `FCHM_ASSERT_NOW(a_below_blue, clk, rst_n, clamped_below, color_blue, "low clamp not blue")

    // A sample above the range shows pure red.
    `FCHM_ASSERT_NOW(a_above_red, clk, rst_n, clamped_above, color_red, "high clamp not red")

endmodule

bind false_color_heat_map_top fchm_checker u_fchm_checker (.*);
